>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/utpe_pkg.sv
package utpe_pkg;

	localparam int unsigned MaxRes = 6;
	localparam int unsigned CntW   = $clog2(MaxRes + 1);
	localparam int unsigned IdxW   = $clog2(MaxRes);

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChTwo     = 8'h32;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChUpperA  = 8'h41;
	localparam logic [7:0] ChNul     = 8'h00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} utpe_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_done;
	} utpe_out_t;

	// All result beats caused by one input beat.
	typedef struct packed {
		logic [MaxRes-1:0][7:0] bytes;
		logic [CntW-1:0]        cnt;
		logic                   marker;
		logic                   eos;
	} utpe_run_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = ChZero + {4'd0, nib};
		end else begin
			d = ChUpperA + {4'd0, nib} - 8'd10;
		end
		return d;
	endfunction

endpackage

>>> rtl/utpe_encode.sv
module utpe_encode (
	input  utpe_pkg::utpe_in_t  item,
	input  logic                seen_text,
	input  logic                pending_space,
	output utpe_pkg::utpe_run_t run,
	output logic                seen_text_next,
	output logic                pending_space_next
);
	import utpe_pkg::*;

	logic [7:0]      b;
	logic            is_ws;
	logic            is_alnum;
	logic            is_punct;
	logic            lead;
	logic [IdxW-1:0] at;
	logic [CntW-1:0] body_n;

	assign b = item.in_byte;

	always_comb begin
		is_ws    = (b >= 8'h09 && b <= 8'h0D) || b == ChSpace;
		is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
		           (b >= 8'h61 && b <= 8'h7A);
		is_punct = !is_alnum && b >= 8'h21 && b <= 8'h7E;
		lead     = pending_space && !is_ws;
		at       = lead ? IdxW'(3) : '0;

		run.bytes  = '0;
		run.marker = 1'b0;
		run.eos    = item.end_of_string;
		body_n     = '0;

		if (lead) begin
			run.bytes[0] = ChPercent;
			run.bytes[1] = ChTwo;
			run.bytes[2] = ChZero;
		end

		// body starts after the collapsed space escape, if any
		if (!is_ws) begin
			if (is_punct) begin
				body_n = CntW'(3);
				run.bytes[at]              = ChPercent;
				run.bytes[at + IdxW'(1)]   = hex_digit(b[7:4]);
				run.bytes[at + IdxW'(2)]   = hex_digit(b[3:0]);
			end else begin
				body_n = CntW'(1);
				run.bytes[at] = is_alnum ? b : ChSpace;
			end
		end

		run.cnt = (lead ? CntW'(3) : CntW'(0)) + body_n;

		// whitespace at the end of a string still owes one empty marker beat
		if (is_ws && item.end_of_string) begin
			run.cnt      = CntW'(1);
			run.marker   = 1'b1;
			run.bytes[0] = ChNul;
		end

		if (item.end_of_string) begin
			seen_text_next     = 1'b0;
			pending_space_next = 1'b0;
		end else if (is_ws) begin
			seen_text_next     = seen_text;
			pending_space_next = pending_space || seen_text;
		end else begin
			seen_text_next     = 1'b1;
			pending_space_next = 1'b0;
		end
	end

endmodule

>>> rtl/url_trim_percent_encoder.sv
// Channel   Beat       Handshake                 Payload
// item      input      item_valid/item_ready     item (utpe_in_t)
// result    output     result_valid/result_ready result (utpe_out_t)
//
// An input beat is classified and encoded combinationally into a run register holding
// 1 to 6 result beats; the run drains one beat a cycle into the output register.
// Sustained rate: one input beat per cycle for single-beat runs; a longer run
// holds item_ready low until its last beat drains (escape 3 beats, pending space +3).
// The drain sets the rate; a low result_ready holds it and item_ready with it.
// Whitespace inside a string produces no beat and loads nothing into the run register.
// Reset clears the run and output valids and the trim state.
`include "assert_macros.svh"

module url_trim_percent_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  utpe_pkg::utpe_in_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output utpe_pkg::utpe_out_t  result
);
	import utpe_pkg::*;

	utpe_run_t       run_next;
	logic            seen_next;
	logic            pending_next;
	logic            seen_q;
	logic            pending_q;

	utpe_run_t       run_s1;
	logic            run_valid_s1;
	logic [IdxW-1:0] idx_q;

	utpe_out_t       out_q;
	logic            out_valid_q;

	logic            accept;
	logic            load_out;
	logic            last_beat;
	logic            run_done;

	utpe_encode u_encode (
		.item               (item),
		.seen_text          (seen_q),
		.pending_space      (pending_q),
		.run                (run_next),
		.seen_text_next     (seen_next),
		.pending_space_next (pending_next)
	);

	assign load_out   = run_valid_s1 && (!out_valid_q || result_ready);
	assign last_beat  = idx_q == IdxW'(run_s1.cnt - CntW'(1));
	assign run_done   = load_out && last_beat;
	assign item_ready = !run_valid_s1 || run_done;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			pending_q <= 1'b0;
		end else if (accept) begin
			seen_q    <= seen_next;
			pending_q <= pending_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (accept && run_next.cnt != '0) begin
				run_valid_s1 <= 1'b1;
				idx_q        <= '0;
			end else if (run_done) begin
				run_valid_s1 <= 1'b0;
			end else if (load_out) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && run_next.cnt != '0) begin
			run_s1 <= run_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.out_byte    <= run_s1.bytes[idx_q];
			out_q.byte_valid  <= !run_s1.marker;
			out_q.run_last    <= last_beat;
			out_q.string_done <= last_beat && run_s1.eos;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`ASSERT_IMPLIES(a_run_idx_in_range, clk, arst_n, run_valid_s1, CntW'(idx_q) < run_s1.cnt)
	`ASSERT_IMPLIES(a_pending_needs_text, clk, arst_n, pending_q, seen_q)
	`ASSERT_IMPLIES(a_done_is_run_last, clk, arst_n, out_valid_q && out_q.string_done, out_q.run_last)
	`ASSERT_IMPLIES(a_marker_ends_string, clk, arst_n, out_valid_q && !out_q.byte_valid, out_q.string_done)
	`ASSERT_NEXT(a_eos_clears_state, clk, arst_n, accept && item.end_of_string, !seen_q && !pending_q)

endmodule

>>> sim/url_trim_percent_encoder_tb.sv
`timescale 1ns / 100ps

module url_trim_percent_encoder_tb;
	import utpe_pkg::*;

	typedef enum int {
		KIND_ALNUM,
		KIND_BLANK,
		KIND_PUNCT,
		KIND_OTHER
	} char_kind_t;

	// Keeps the encoder's trim state and the queue of beats it still owes.
	class encoded_stream_board;
		utpe_out_t due_beats[$];
		bit        in_word;
		bit        space_owed;
		int        fails;

		function bit blank(logic [7:0] b);
			return (b >= 8'h09 && b <= 8'h0D) || b == ChSpace;
		endfunction

		function bit alnum(logic [7:0] b);
			return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
				(b >= 8'h61 && b <= 8'h7A);
		endfunction

		function logic [7:0] hex_char(logic [3:0] nib);
			if (nib < 4'd10) begin
				return ChZero + 8'(nib);
			end
			return ChUpperA + 8'(nib) - 8'd10;
		endfunction

		function void put(logic [7:0] b, logic valid);
			utpe_out_t beat;
			beat.out_byte    = b;
			beat.byte_valid  = valid;
			beat.run_last    = 1'b0;
			beat.string_done = 1'b0;
			due_beats.push_back(beat);
		endfunction

		function void put_escape(logic [7:0] b);
			put(ChPercent, 1'b1);
			put(hex_char(b[7:4]), 1'b1);
			put(hex_char(b[3:0]), 1'b1);
		endfunction

		function void take_char(utpe_in_t c);
			int first;
			first = due_beats.size();
			if (blank(c.in_byte)) begin
				if (in_word) begin
					space_owed = 1'b1;
				end
			end else begin
				if (space_owed) begin
					put_escape(ChSpace);
					space_owed = 1'b0;
				end
				if (alnum(c.in_byte)) begin
					put(c.in_byte, 1'b1);
				end else if (c.in_byte >= 8'h21 && c.in_byte <= 8'h7E) begin
					put_escape(c.in_byte);
				end else begin
					put(ChSpace, 1'b1);
				end
				in_word = 1'b1;
			end
			if (c.end_of_string) begin
				// nothing left to say: an empty marker closes the string
				if (due_beats.size() == first) begin
					put(ChNul, 1'b0);
				end
				due_beats[$].string_done = 1'b1;
				in_word    = 1'b0;
				space_owed = 1'b0;
			end
			if (due_beats.size() > first) begin
				due_beats[$].run_last = 1'b1;
			end
		endfunction

		function void match_beat(utpe_out_t got);
			utpe_out_t want;
			if (due_beats.size() == 0) begin
				$error("unexpected result beat %h", got);
				fails++;
				return;
			end
			want = due_beats.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
				fails++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
				fails++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				fails++;
			end
			if (got.string_done !== want.string_done) begin
				$error("string_done: expected %b, got %b", want.string_done,
					got.string_done);
				fails++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	utpe_in_t  item;
	logic      result_valid;
	logic      result_ready;
	utpe_out_t result;

	encoded_stream_board board = new();
	bit gaps_on = 1'b1;

	url_trim_percent_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic send_char(input logic [7:0] b, input logic eos);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item_valid         = 1'b1;
		item.in_byte       = b;
		item.end_of_string = eos;
		do @(posedge clk); while (!item_ready);
		board.take_char(item);
	endtask

	function automatic logic [7:0] pick_char(char_kind_t kind);
		logic [7:0] b;
		case (kind)
		KIND_ALNUM: begin
			case ($urandom_range(0, 2))
			0: b = 8'($urandom_range(8'h30, 8'h39));
			1: b = 8'($urandom_range(8'h41, 8'h5A));
			default: b = 8'($urandom_range(8'h61, 8'h7A));
			endcase
		end
		KIND_BLANK: begin
			b = ($urandom_range(0, 2) == 0) ? ChSpace : 8'($urandom_range(8'h09, 8'h0D));
		end
		KIND_PUNCT: begin
			do b = 8'($urandom_range(8'h21, 8'h7E));
			while (board.alnum(b));
		end
		default: begin
			// control bytes outside the blank set, DEL and the top half
			do b = 8'($urandom_range(8'h01, 8'hFF));
			while (board.blank(b) || (b >= 8'h21 && b <= 8'h7E));
		end
		endcase
		return b;
	endfunction

	// result side: ready drops in short bursts while gaps are on
	initial begin
		int stall_left;
		stall_left   = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready = 1'b0;
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				result_ready = 1'b0;
				stall_left   = $urandom_range(1, 5) - 1;
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			board.match_beat(result);
		end
	end

	initial begin
		logic [8:0] opening[$];
		int         sent;
		int         len;
		bit         blank_only;
		char_kind_t kind;

		// {byte, end of string}
		opening = '{
			{8'h20, 1'b0}, {8'h09, 1'b0}, {8'h41, 1'b0}, {8'h0D, 1'b0},
			{8'h0A, 1'b0}, {8'h30, 1'b0}, {8'h21, 1'b0}, {8'h7E, 1'b0},
			{8'h25, 1'b0}, {8'h20, 1'b0}, {8'h7F, 1'b0}, {8'h20, 1'b0},
			{8'h7E, 1'b0}, {8'hFF, 1'b0}, {8'h01, 1'b0}, {8'h7A, 1'b0},
			{8'h0B, 1'b0}, {8'h0C, 1'b1},
			{8'h20, 1'b1},
			{8'h5A, 1'b1},
			{8'h39, 1'b0}, {8'h80, 1'b1},
			{8'h61, 1'b0}, {8'h20, 1'b0}, {8'h2F, 1'b1}
		};

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i]) begin
			send_char(opening[i][8:1], opening[i][0]);
		end

		sent = opening.size();
		while (sent < 360) begin
			len        = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) :
				$urandom_range(1, 12);
			blank_only = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3: kind = KIND_ALNUM;
				4, 5: kind = KIND_BLANK;
				6, 7: kind = KIND_PUNCT;
				default: kind = KIND_OTHER;
				endcase
				if (blank_only) begin
					kind = KIND_BLANK;
				end
				// closing stretch runs flat out on both sides
				if (sent >= 300) begin
					gaps_on = 1'b0;
				end
				send_char(pick_char(kind), i == len - 1);
				sent++;
			end
		end

		@(negedge clk);
		item_valid = 1'b0;
		while (board.due_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (board.fails == 0) begin
			$display("url_trim_percent_encoder verification clean");
		end else begin
			$display("url_trim_percent_encoder verification failed");
		end
		$finish;
	end

	// watchdog: reports a failure and stops the run if it has not finished
	initial begin
		#2_000_000;
		$display("url_trim_percent_encoder verification failed");
		$finish;
	end

endmodule
